[rtl/assert_macros.svh]
// Assertion helpers used by polyline_decimate_cull.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: lbl");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: lbl");

`else

`define ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

[rtl/pdc_pkg.sv]
`default_nettype none

package pdc_pkg;

  localparam int unsigned CoordW = 16;
  localparam int unsigned CountW = 16;

  // Outcode bits
  localparam logic [3:0] CODE_LEFT   = 4'b0001;
  localparam logic [3:0] CODE_RIGHT  = 4'b0010;
  localparam logic [3:0] CODE_TOP    = 4'b0100;
  localparam logic [3:0] CODE_BOTTOM = 4'b1000;

  // Road class with its own budget
  localparam logic [1:0] CLASS_ARTERY = 2'd2;

  localparam logic [CountW-1:0] BUDGET_ARTERY = 16'd900;
  localparam logic [CountW-1:0] BUDGET_OTHER  = 16'd400;
  localparam logic [CountW-1:0] COUNT_MAX     = 16'hFFFF;

  // Configuration register indexes
  localparam logic [2:0] REG_AREA_LEFT    = 3'd0;
  localparam logic [2:0] REG_AREA_TOP     = 3'd1;
  localparam logic [2:0] REG_AREA_RIGHT   = 3'd2;
  localparam logic [2:0] REG_AREA_BOTTOM  = 3'd3;
  localparam logic [2:0] REG_MIN_STEP     = 3'd4;
  localparam logic [2:0] REG_FRAME_BUDGET = 3'd5;

  typedef struct packed {
    logic signed [CoordW-1:0] from_x;
    logic signed [CoordW-1:0] from_y;
    logic signed [CoordW-1:0] to_x;
    logic signed [CoordW-1:0] to_y;
    logic [1:0]               seg_class;
  } seg_t;

  function automatic logic [CountW-1:0] sat_inc(input logic [CountW-1:0] v);
    return (v != COUNT_MAX) ? v + 16'd1 : v;
  endfunction

  function automatic logic [CountW-1:0] budget_of(input logic [1:0] cls);
    return (cls == CLASS_ARTERY) ? BUDGET_ARTERY : BUDGET_OTHER;
  endfunction

endpackage

`default_nettype wire

[rtl/pdc_skid.sv]
`default_nettype none

// Two-entry output buffer: a main register that drives the port and a
// skid register that catches one item while the port is stalled.
module pdc_skid (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire pdc_pkg::seg_t push_data,
  output logic               full,
  output logic               seg_valid,
  input  wire logic          seg_stall,
  output pdc_pkg::seg_t      seg_data
);

  logic          main_valid;
  logic          skid_valid;
  pdc_pkg::seg_t main_data;
  pdc_pkg::seg_t skid_data;
  logic          pop;

  assign pop       = main_valid && !seg_stall;
  assign full      = skid_valid;
  assign seg_valid = main_valid;
  assign seg_data  = main_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      // upstream is held while the skid is full, so no push here
      if (pop) begin
        main_valid <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (!main_valid || pop) begin
      main_valid <= push;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        main_data <= skid_data;
      end
    end else if (!main_valid || pop) begin
      main_data <= push_data;
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule

`default_nettype wire

[rtl/polyline_decimate_cull.sv]
`default_nettype none

// Channel   | Dir | Handshake                 | Payload
// ----------+-----+---------------------------+-------------------------------------------
// point     | in  | pt_valid / pt_stall       | rel_x, rel_y, road_class, way_start,
//           |     |                           | way_last, frame_start
// segment   | out | seg_valid / seg_stall     | from_x, from_y, to_x, to_y, seg_class
// config    | in  | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
// One point item per cycle while pt_stall is low. Each point is fully handled in the
// cycle it is accepted; its segment, if any, is registered in the output buffer
// before it shows on the output, later while older segments wait behind seg_stall.
// A two-entry output buffer holds results while seg_stall is high; pt_stall
// rises only once both entries are full.
// Reset (rst, synchronous) restores the view rectangle 0..239, min_step 3,
// frame budget 1400, and clears all counters and way state.
// cfg_ready is always high; write configuration only while the block is idle.

`include "assert_macros.svh"

module polyline_decimate_cull #(
  parameter int NUM_CLASSES = 4
) (
  input  wire logic               clk,
  input  wire logic               rst,
  // point channel
  input  wire logic               pt_valid,
  output logic                    pt_stall,
  input  wire logic signed [15:0] rel_x,
  input  wire logic signed [15:0] rel_y,
  input  wire logic [1:0]         road_class,
  input  wire logic               way_start,
  input  wire logic               way_last,
  input  wire logic               frame_start,
  // segment channel
  output logic                    seg_valid,
  input  wire logic               seg_stall,
  output logic signed [15:0]      from_x,
  output logic signed [15:0]      from_y,
  output logic signed [15:0]      to_x,
  output logic signed [15:0]      to_y,
  output logic [1:0]              seg_class,
  // configuration channel
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [15:0]        cfg_data
);

  // Configuration registers
  logic signed [15:0] area_left;
  logic signed [15:0] area_top;
  logic signed [15:0] area_right;
  logic signed [15:0] area_bottom;
  logic [7:0]         min_step;
  logic [15:0]        frame_budget;

  // Way and counter state
  logic signed [15:0] last_x;
  logic signed [15:0] last_y;
  logic [3:0]         last_code;
  logic               have_last;
  logic               way_accepted;
  logic [15:0]        frame_count;
  logic [15:0]        class_segs [NUM_CLASSES];

  logic               have_last_next;
  logic               way_accepted_next;
  logic [15:0]        frame_count_next;
  logic [15:0]        class_segs_next [NUM_CLASSES];

  // Per-point working values
  logic               accept;
  logic               cls_ok;
  logic [15:0]        fc_eff;
  logic [15:0]        cc_eff [NUM_CLASSES];
  logic [15:0]        cc_sel;
  logic               accepted_eff;
  logic               have_eff;
  logic signed [15:0] px;
  logic signed [15:0] py;
  logic [3:0]         code;
  logic signed [16:0] diff_x;
  logic signed [16:0] diff_y;
  logic [15:0]        abs_x;
  logic [15:0]        abs_y;
  logic [16:0]        step_len;
  logic               near;
  logic               keep;
  logic               emit;
  pdc_pkg::seg_t      seg_new;
  pdc_pkg::seg_t      seg_out;
  logic               buf_full;

  assign cfg_ready = 1'b1;
  assign accept    = pt_valid && !pt_stall;
  assign pt_stall  = buf_full;

  // Config write decode
  always_ff @(posedge clk) begin
    if (rst) begin
      area_left    <= 16'sd0;
      area_top     <= 16'sd0;
      area_right   <= 16'sd239;
      area_bottom  <= 16'sd239;
      min_step     <= 8'd3;
      frame_budget <= 16'd1400;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pdc_pkg::REG_AREA_LEFT:    area_left    <= cfg_data;
        pdc_pkg::REG_AREA_TOP:     area_top     <= cfg_data;
        pdc_pkg::REG_AREA_RIGHT:   area_right   <= cfg_data;
        pdc_pkg::REG_AREA_BOTTOM:  area_bottom  <= cfg_data;
        pdc_pkg::REG_MIN_STEP:     min_step     <= cfg_data[7:0];
        pdc_pkg::REG_FRAME_BUDGET: frame_budget <= cfg_data;
        default: ;
      endcase
    end
  end

  // Point handling: frame clear, then way accept decision, then the point.
  always_comb begin
    cls_ok = (32'(road_class) < NUM_CLASSES);

    // frame_start clears the counters ahead of everything else
    fc_eff = frame_start ? 16'd0 : frame_count;
    cc_sel = 16'd0;
    for (int i = 0; i < NUM_CLASSES; i++) begin
      cc_eff[i] = frame_start ? 16'd0 : class_segs[i];
      if (32'(road_class) == i) begin
        cc_sel = cc_eff[i];
      end
    end

    // a new way is taken only while both budgets have room
    if (way_start) begin
      accepted_eff = cls_ok && (fc_eff < frame_budget) &&
                     (cc_sel < pdc_pkg::budget_of(road_class));
      have_eff     = 1'b0;
    end else begin
      accepted_eff = way_accepted;
      have_eff     = have_last;
    end

    // screen position, wrapping to 16 bits
    px = area_left + rel_x;
    py = area_top + rel_y;

    code = 4'b0000;
    if (px < area_left) begin
      code = code | pdc_pkg::CODE_LEFT;
    end else if (px > area_right) begin
      code = code | pdc_pkg::CODE_RIGHT;
    end
    if (py < area_top) begin
      code = code | pdc_pkg::CODE_TOP;
    end else if (py > area_bottom) begin
      code = code | pdc_pkg::CODE_BOTTOM;
    end

    // Manhattan distance from the last kept point
    diff_x   = 17'(px) - 17'(last_x);
    diff_y   = 17'(py) - 17'(last_y);
    abs_x    = diff_x[16] ? 16'(-diff_x) : diff_x[15:0];
    abs_y    = diff_y[16] ? 16'(-diff_y) : diff_y[15:0];
    step_len = {1'b0, abs_x} + {1'b0, abs_y};

    // fold a short step unless it ends the way
    near = have_eff && (step_len < {9'd0, min_step}) && !way_last;
    keep = !near;
    emit = accept && accepted_eff && have_eff && !near &&
           ((code & last_code) == 4'b0000) && cls_ok;

    seg_new.from_x    = last_x;
    seg_new.from_y    = last_y;
    seg_new.to_x      = px;
    seg_new.to_y      = py;
    seg_new.seg_class = road_class;

    frame_count_next = emit ? pdc_pkg::sat_inc(fc_eff) : fc_eff;
    for (int i = 0; i < NUM_CLASSES; i++) begin
      class_segs_next[i] = (emit && (32'(road_class) == i)) ?
                           pdc_pkg::sat_inc(cc_eff[i]) : cc_eff[i];
    end

    // a rejected way leaves the way state as the start left it
    if (!accepted_eff) begin
      have_last_next    = have_eff;
      way_accepted_next = 1'b0;
    end else begin
      have_last_next    = way_last ? 1'b0 : (keep || have_eff);
      way_accepted_next = !way_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_x       <= 16'sd0;
      last_y       <= 16'sd0;
      last_code    <= 4'b0000;
      have_last    <= 1'b0;
      way_accepted <= 1'b0;
      frame_count  <= 16'd0;
      for (int i = 0; i < NUM_CLASSES; i++) begin
        class_segs[i] <= 16'd0;
      end
    end else if (accept) begin
      have_last    <= have_last_next;
      way_accepted <= way_accepted_next;
      frame_count  <= frame_count_next;
      for (int i = 0; i < NUM_CLASSES; i++) begin
        class_segs[i] <= class_segs_next[i];
      end
      // advance the anchor only for kept points of an accepted way
      if (accepted_eff && keep) begin
        last_x    <= px;
        last_y    <= py;
        last_code <= code;
      end
    end
  end

  pdc_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (emit),
    .push_data (seg_new),
    .full      (buf_full),
    .seg_valid (seg_valid),
    .seg_stall (seg_stall),
    .seg_data  (seg_out)
  );

  assign from_x    = seg_out.from_x;
  assign from_y    = seg_out.from_y;
  assign to_x      = seg_out.to_x;
  assign to_y      = seg_out.to_y;
  assign seg_class = seg_out.seg_class;

  // input is held only behind a full buffer, which implies a pending result
  `ASSERT_IMPL(a_stall_has_result, clk, rst, pt_stall, seg_valid)
  // after a segment is made, the output holds a valid segment next cycle
  `ASSERT_NEXT(a_emit_shows, clk, rst, emit, seg_valid)
  // the frame counter only drops on a frame start
  `ASSERT_NEXT(a_frame_count_up, clk, rst, !(accept && frame_start),
               frame_count >= $past(frame_count))

endmodule

`default_nettype wire
